FILE: hw/rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the burst median filter: request and
// response payloads, sequencer states and default sizing.
// ----------------------------------------------------------------------------
package smf_pkg;

   // default sizing of the sample store
   localparam int MAX_SAMPLES_DEF = 15;
   localparam int SAMPLE_BITS_DEF = 12;

   // fixed widths of the payload fields
   localparam int SAMPLE_W = 12;
   localparam int COUNT_W  = 4;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_sample;
   } smf_req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] median;
      logic [COUNT_W-1:0]  used_count;
   } smf_rsp_type;

   // selection sequencer
   typedef enum logic [2:0] {
      S_IDLE,
      S_CAND,
      S_LATCH,
      S_SCAN,
      S_DECIDE
   } smf_state_type;

endpackage

FILE: hw/rtl/sample_median_filter.sv
// ----------------------------------------------------------------------------
// sample_median_filter
// Collects a burst of converter samples into a small sample memory and, when
// the flagged last sample arrives, selects the sorted element at index
// count/2 by ranking each stored candidate against all kept samples.
// ----------------------------------------------------------------------------
//
//   channel   ports                     handshake
//   --------  ------------------------  -----------------------------------
//   request   req_data                  taken when start && !busy
//   response  rsp_data                  valid for one cycle with rsp_valid
//
// A request without the last flag is taken while busy stays low.
// A flagged request closing a burst of n kept samples holds busy while up to
// n candidates are tried: each costs a read, a latch, n compare reads and
// a decision, all through the single read port of the sample memory.
// The response strobe rises in the cycle after the decision; it cannot stall.
// Reset clears the kept count and the sequencer; the memory is not cleared.
//
module sample_median_filter
   import smf_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  smf_req_type req_data,
   output logic        rsp_valid,
   output smf_rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int EXT_W  = SAMPLE_BITS + SAMPLE_W;
   localparam int CEXT_W = CNT_W + COUNT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

   // sample memory, one write and one registered read port
   logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;

   smf_state_type state_ff, state_in;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       i_ff, i_in;
   logic [CNT_W-1:0]       j_ff, j_in;
   logic [CNT_W-1:0]       rank_ff, rank_in;
   logic [SAMPLE_BITS-1:0] cand_ff, cand_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   smf_rsp_type            rsp_ff, rsp_in;

   logic                   accept;
   logic                   room;
   logic                   less;
   logic [CNT_W-1:0]       cmp_idx;
   logic [CNT_W-1:0]       half;
   logic [EXT_W-1:0]       smp_ext;
   logic [EXT_W-1:0]       med_ext;
   logic [CEXT_W-1:0]      cnt_ext;

   assign accept  = start && (state_ff == S_IDLE);
   assign room    = count_ff < MAX_CNT;
   assign busy    = (state_ff != S_IDLE);
   assign half    = count_ff >> 1;
   assign cmp_idx = j_ff - CNT_W'(1);

   // keep the low sample bits of the request field
   assign smp_ext = {{SAMPLE_BITS{1'b0}}, req_data.sample};
   assign wr_data = smp_ext[SAMPLE_BITS-1:0];
   assign wr_en   = accept && room;
   assign wr_addr = count_ff[ADDR_W-1:0];

   // stable rank order: equal values ranked by their position
   assign less = (rd_data_ff < cand_ff) ||
                 ((rd_data_ff == cand_ff) && (cmp_idx < i_ff));

   assign med_ext = {{SAMPLE_W{1'b0}}, cand_ff};
   assign cnt_ext = {{COUNT_W{1'b0}}, count_ff};

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.last_sample) begin
               state_in = S_CAND;
            end
         end
         S_CAND:  state_in = S_LATCH;
         S_LATCH: state_in = S_SCAN;
         S_SCAN: begin
            if (j_ff >= count_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (rank_ff == half) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_CAND;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rank_in      = rank_ff;
      cand_in      = cand_ff;
      rd_addr      = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
            i_in = '0;
         end
         S_CAND: begin
            rd_addr = i_ff[ADDR_W-1:0];
         end
         S_LATCH: begin
            cand_in = rd_data_ff;
            rd_addr = '0;
            j_in    = CNT_W'(1);
            rank_in = '0;
         end
         S_SCAN: begin
            if (less) begin
               rank_in = rank_ff + CNT_W'(1);
            end
            if (j_ff < count_ff) begin
               rd_addr = j_ff[ADDR_W-1:0];
               j_in    = j_ff + CNT_W'(1);
            end
         end
         S_DECIDE: begin
            if (rank_ff == half) begin
               rsp_valid_in      = 1'b1;
               rsp_in.median     = med_ext[SAMPLE_W-1:0];
               rsp_in.used_count = cnt_ext[COUNT_W-1:0];
               count_in          = '0;
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      rank_ff <= rank_in;
      cand_ff <= cand_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // kept count never passes the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("kept count beyond store depth");

   // a response follows a decision and leaves the count cleared
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_DECIDE) && (count_ff == '0))
      else $error("response without a closing decision");

   // candidates stay inside the kept samples
   a_cand_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CAND) |-> (i_ff < count_ff))
      else $error("candidate index beyond kept samples");

   // scan index stays inside the burst
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (j_ff != '0) && (j_ff <= count_ff))
      else $error("scan index out of range");

endmodule
